FILE: design/fir_dec_pkg.sv
// ============================================================================
// fir_dec_pkg
// Shared types and constants for the decimating Q15 FIR filter.
// ============================================================================
package fir_dec_pkg;

    localparam int TAPS_DEF   = 7;
    localparam int DECIM_DEF  = 5;
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int Q_SHIFT    = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MODE_W     = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF0 = 3'd1;

    localparam logic [MODE_W-1:0] MODE_IDENT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FIR   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DECIM = 2'd2;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic valid;
        logic ident;
    } t_line_stat;

endpackage

FILE: design/fir_filter_with_decimation_unit.sv
// ============================================================================
// fir_filter_with_decimation_unit
// Q15 FIR filter with identity, per-sample and decimate-by-N modes.
// ============================================================================
//  Channel   Signals                                 Direction
//  input     i_in_valid, o_in_stall, i_sample        sample in
//  output    o_out_valid, i_out_stall, o_filtered    result out
//  config    i_cfg_we, i_cfg_idx, i_cfg_data         register write
//
// One sample is taken per cycle while o_in_stall is low. The stages are the
// delay line, the tap products and the sum into the output register. Reset
// clears the delay line, the phase, the mode and the coefficients. A stalled
// output holds back the pipeline only once every stage is full.
// ============================================================================
module fir_filter_with_decimation_unit
    import fir_dec_pkg::*;
#(
    parameter int TAPS         = TAPS_DEF,
    parameter int DECIM_FACTOR = DECIM_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [SAMPLE_W-1:0]   i_sample,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [SAMPLE_W-1:0]   o_filtered
);

    t_cfg_wr                    cfg;
    t_line_stat                 stat;
    logic signed [SAMPLE_W-1:0] line [TAPS];
    logic                       take;
    logic                       accept;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    assign o_in_stall = stat.valid && !take;
    assign accept     = i_in_valid && !o_in_stall;

    fir_dec_line #(
        .TAPS         (TAPS),
        .DECIM_FACTOR (DECIM_FACTOR)
    ) u_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_accept (accept),
        .i_sample (i_sample),
        .i_take   (take),
        .o_line   (line),
        .o_stat   (stat)
    );

    fir_dec_mac #(
        .TAPS (TAPS)
    ) u_mac (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_line      (line),
        .i_stat      (stat),
        .i_out_stall (i_out_stall),
        .o_take      (take),
        .o_out_valid (o_out_valid),
        .o_filtered  (o_filtered)
    );

endmodule

FILE: design/fir_dec_line.sv
// ============================================================================
// fir_dec_line
// Delay line, mode register and decimation phase; marks which samples give
// a result.
// ============================================================================
module fir_dec_line
    import fir_dec_pkg::*;
#(
    parameter int TAPS         = TAPS_DEF,
    parameter int DECIM_FACTOR = DECIM_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg_wr                    i_cfg,
    input  logic                       i_accept,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_take,
    output logic signed [SAMPLE_W-1:0] o_line [TAPS],
    output t_line_stat                 o_stat
);

    localparam int PH_W = $clog2(DECIM_FACTOR);
    localparam logic [PH_W-1:0] PH_LAST = PH_W'(DECIM_FACTOR - 1);

    logic [MODE_W-1:0]          r_mode;
    logic signed [SAMPLE_W-1:0] r_line [TAPS];
    logic [PH_W-1:0]            r_phase;
    logic [PH_W-1:0]            n_phase;
    logic                       r_valid;
    logic                       r_ident;
    logic                       n_emit;
    logic                       n_ident;

    always_comb begin
        n_phase = '0;
        n_emit  = 1'b1;
        n_ident = 1'b0;
        case (r_mode)
            MODE_FIR: begin
                n_ident = 1'b0;
            end
            MODE_DECIM: begin
                if (r_phase >= PH_LAST) begin
                    n_phase = '0;
                end else begin
                    n_phase = r_phase + 1'b1;
                    n_emit  = 1'b0;
                end
            end
            default: begin
                n_ident = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDENT;
            r_phase <= '0;
            r_valid <= 1'b0;
            r_ident <= 1'b0;
            for (int k = 0; k < TAPS; k++) begin
                r_line[k] <= '0;
            end
        end else begin
            if (i_cfg.we && i_cfg.idx == CFG_MODE) begin
                r_mode <= i_cfg.data[MODE_W-1:0];
            end
            if (i_accept) begin
                r_line[0] <= i_sample;
                for (int k = 1; k < TAPS; k++) begin
                    r_line[k] <= r_line[k-1];
                end
                r_phase <= n_phase;
                r_valid <= n_emit;
                r_ident <= n_ident;
            end else if (i_take) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_line       = r_line;
    assign o_stat.valid = r_valid;
    assign o_stat.ident = r_ident;

endmodule

FILE: design/fir_dec_mac.sv
// ============================================================================
// fir_dec_mac
// Coefficient registers, parallel tap products, sum and output register.
// ============================================================================
module fir_dec_mac
    import fir_dec_pkg::*;
#(
    parameter int TAPS = TAPS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg_wr                    i_cfg,
    input  logic signed [SAMPLE_W-1:0] i_line [TAPS],
    input  t_line_stat                 i_stat,
    input  logic                       i_out_stall,
    output logic                       o_take,
    output logic                       o_out_valid,
    output logic signed [SAMPLE_W-1:0] o_filtered
);

    logic signed [SAMPLE_W-1:0] r_coef [TAPS];
    logic signed [PROD_W-1:0]   r_prod [TAPS];
    logic                       r_v1;
    logic                       r_ident1;
    logic signed [SAMPLE_W-1:0] r_pass1;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_filtered;
    logic signed [PROD_W-1:0]   n_acc;
    logic                       out_free;
    logic                       s1_free;

    assign out_free = !r_out_valid || !i_out_stall;
    assign s1_free  = !r_v1 || out_free;
    assign o_take   = i_stat.valid && s1_free;

    always_comb begin
        n_acc = '0;
        for (int k = 0; k < TAPS; k++) begin
            n_acc = n_acc + r_prod[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TAPS; k++) begin
                r_coef[k] <= '0;
            end
        end else if (i_cfg.we) begin
            for (int k = 0; k < TAPS; k++) begin
                if (i_cfg.idx == CFG_COEF0 + CFG_IDX_W'(k)) begin
                    r_coef[k] <= i_cfg.data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_v1 <= i_stat.valid;
            end
            if (out_free) begin
                r_out_valid <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            for (int k = 0; k < TAPS; k++) begin
                r_prod[k] <= i_line[k] * r_coef[k];
            end
            r_ident1 <= i_stat.ident;
            r_pass1  <= i_line[0];
        end
        if (r_v1 && out_free) begin
            r_filtered <= r_ident1 ? r_pass1 : n_acc[Q_SHIFT+SAMPLE_W-1:Q_SHIFT];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_filtered  = r_filtered;

endmodule

FILE: design/fir_dec_chk.sv
// ============================================================================
// fir_dec_chk
// Port-level checks for the decimating FIR filter.
// ============================================================================
module fir_dec_chk
    import fir_dec_pkg::*;
(
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic signed [SAMPLE_W-1:0] o_filtered
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_filtered))
        else $error("Stalled result changed or vanished.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("Pipeline not empty after reset.");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("Input stalled while the output side can move.");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_stall |-> !o_in_stall)
        else $error("Input stalled while the output side accepts a transfer.");

endmodule

bind fir_filter_with_decimation_unit fir_dec_chk u_chk (.*);

FILE: sim/testbench.sv
// ============================================================================
// testbench
// Self-checking testbench for the decimating Q15 FIR filter. A directed
// opening drives extreme samples and coefficients through every mode, then
// randomized blocks reprogram the filter and stream samples under varying
// sender and receiver idling. Each transfer into the block updates an
// internal filter model, and every result transfer is checked against the
// oldest predicted value.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
    import fir_dec_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_TICKS = 8;
    localparam int COEF_MAX     = 0;
    localparam int COEF_MIN     = 1;
    localparam int COEF_IMPULSE = 2;
    localparam int COEF_RANDOM  = 3;
    localparam logic [MODE_W-1:0] BLOCK_MODES [6] =
        '{MODE_FIR, MODE_DECIM, MODE_IDENT, MODE_DECIM, MODE_FIR, MODE_SPARE};

    logic                        i_clk     = 1'b0;
    logic                        i_rst_n   = 1'b0;
    logic                        cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]        cfg_idx   = '0;
    logic [CFG_DATA_W-1:0]       cfg_data  = '0;
    logic                        in_valid  = 1'b0;
    logic signed [SAMPLE_W-1:0]  in_sample = '0;
    logic                        out_stall = 1'b0;
    logic                        in_stall;
    logic                        out_valid;
    logic signed [SAMPLE_W-1:0]  filtered;

    fir_filter_with_decimation_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_sample    (in_sample),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_filtered  (filtered)
    );

    always #5 i_clk = ~i_clk;

    // Filter model state.
    logic [MODE_W-1:0]          model_mode;
    logic signed [SAMPLE_W-1:0] model_coef [TAPS_DEF];
    logic signed [SAMPLE_W-1:0] model_history [TAPS_DEF];
    int unsigned                model_phase;

    logic signed [SAMPLE_W-1:0] pending_samples [$];
    logic signed [SAMPLE_W-1:0] expected_filtered [$];

    int  tx_idle_pct  = 17;
    int  rx_idle_pct  = 56;
    int  hold_left    = 0;
    int  mismatches   = 0;
    int  cycle_count  = 0;
    bit  sample_taken = 1'b0;

    function automatic logic signed [SAMPLE_W-1:0] tap_sum();
        logic signed [63:0] acc;
        acc = '0;
        for (int k = 0; k < TAPS_DEF; k++) begin
            acc += 64'(model_coef[k]) * 64'(model_history[k]);
        end
        return acc[Q_SHIFT +: SAMPLE_W];
    endfunction

    function automatic void filter_sample(input logic signed [SAMPLE_W-1:0] s);
        for (int k = TAPS_DEF - 1; k > 0; k--) begin
            model_history[k] = model_history[k-1];
        end
        model_history[0] = s;
        case (model_mode)
            MODE_FIR: begin
                model_phase = 0;
                expected_filtered.push_back(tap_sum());
            end
            MODE_DECIM: begin
                if (model_phase >= DECIM_DEF - 1) begin
                    model_phase = 0;
                    expected_filtered.push_back(tap_sum());
                end else begin
                    model_phase = model_phase + 1;
                end
            end
            default: begin
                model_phase = 0;
                expected_filtered.push_back(s);
            end
        endcase
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sh0000;
            3:       return -16'sd1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic signed [SAMPLE_W-1:0] got,
                                   input logic signed [SAMPLE_W-1:0] want);
        $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx == CFG_MODE) begin
            model_mode = data[MODE_W-1:0];
        end else begin
            model_coef[idx - CFG_COEF0] = data;
        end
    endtask

    task automatic program_filter(input logic [MODE_W-1:0] m, input int kind);
        logic [CFG_DATA_W-1:0]      mode_word;
        logic signed [SAMPLE_W-1:0] c;
        mode_word = CFG_DATA_W'($urandom);
        mode_word[MODE_W-1:0] = m;
        write_reg(CFG_MODE, mode_word);
        for (int k = 0; k < TAPS_DEF; k++) begin
            case (kind)
                COEF_MAX:     c = 16'sh7FFF;
                COEF_MIN:     c = 16'sh8000;
                COEF_IMPULSE: c = (k == 0) ? 16'sh7FFF : 16'sh0000;
                default:      c = SAMPLE_W'($urandom);
            endcase
            write_reg(CFG_IDX_W'(CFG_COEF0 + k), c);
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || in_valid || expected_filtered.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_TICKS) @(posedge i_clk);
    endtask

    // Sender: a new sample is offered only when the previous one has transferred.
    always @(negedge i_clk) begin
        if (!in_valid || sample_taken) begin
            if (i_rst_n && pending_samples.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                in_valid  <= 1'b1;
                in_sample <= pending_samples.pop_front();
            end else begin
                in_valid <= 1'b0;
            end
        end
        sample_taken = 1'b0;
    end

    // Receiver: random stalls, or a counted hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                if (expected_filtered.size() == 0) begin
                    report_mismatch("result with nothing expected", filtered, '0);
                end else if (filtered !== expected_filtered[0]) begin
                    report_mismatch("filtered", filtered, expected_filtered.pop_front());
                end else begin
                    void'(expected_filtered.pop_front());
                end
            end
            if (in_valid && !in_stall) begin
                filter_sample(in_sample);
                sample_taken = 1'b1;
            end
        end
    end

    initial begin
        model_mode  = MODE_IDENT;
        model_phase = 0;
        for (int k = 0; k < TAPS_DEF; k++) begin
            model_coef[k]    = '0;
            model_history[k] = '0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed opening in the reset configuration and then each mode.
        pending_samples.push_back(16'sh8000);
        pending_samples.push_back(16'sh7FFF);
        pending_samples.push_back(16'sh0000);
        drain();

        program_filter(MODE_FIR, COEF_MIN);
        repeat (7) pending_samples.push_back(16'sh8000);
        repeat (2) pending_samples.push_back(16'sh7FFF);
        drain();

        program_filter(MODE_DECIM, COEF_MAX);
        repeat (10) pending_samples.push_back(random_sample());
        drain();

        program_filter(MODE_SPARE, COEF_IMPULSE);
        pending_samples.push_back(-16'sd1);
        pending_samples.push_back(16'sh0001);
        drain();

        // Randomized blocks with three idling profiles.
        for (int b = 0; b < 12; b++) begin
            tx_idle_pct = (b < 4) ? 17 : (b < 8) ? 56 : 0;
            rx_idle_pct = (b < 4) ? 56 : (b < 8) ? 17 : 0;
            program_filter(BLOCK_MODES[b % 6],
                           (b % 4 == 0) ? int'($urandom_range(0, 2)) : COEF_RANDOM);
            repeat (32) pending_samples.push_back(random_sample());
            if (b == 10) begin
                @(posedge i_clk);
                hold_left = 60;
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
